// ----- design/apsp_pkg.sv -----
package apsp_pkg;

  // Default sizing
  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int MAX_RESULTS      = 16;

  // Opcodes
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_RUN   = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_PATH  = 3'd4;

  localparam logic [4:0] VCOUNT_RESET = 5'd16;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] weight;
  } apsp_in_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic               reachable;
    logic [3:0]         next_hop;
    logic [3:0]         prev_hop;
    logic               neg_cycle;
    logic [3:0]         path_vertex;
    logic               last;
  } apsp_out_t;

endpackage

// ----- design/apsp_mem.sv -----
module apsp_mem import apsp_pkg::*; #(
  parameter int AW = 2 * $clog2(MAX_VERTICES_DEF),
  parameter int DW = 33 + 2 * $clog2(MAX_VERTICES_DEF)
) (
  input  logic          clk,
  input  logic          rd_a_en,
  input  logic [AW-1:0] rd_a_addr,
  output logic [DW-1:0] rd_a_data,
  input  logic          rd_b_en,
  input  logic [AW-1:0] rd_b_addr,
  output logic [DW-1:0] rd_b_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_a_data_r;
  logic [DW-1:0] rd_b_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rd_a_data_r <= mem[rd_a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_b_en) begin
      rd_b_data_r <= mem[rd_b_addr];
    end
  end

  assign rd_a_data = rd_a_data_r;
  assign rd_b_data = rd_b_data_r;

endmodule

// ----- design/apsp_alu.sv -----
// Saturating add with registered sum, plus the relax compare.
module apsp_alu (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic signed [31:0] cur,
  input  logic               cur_valid,
  output logic signed [31:0] sum,
  output logic               better
);

  logic signed [32:0] wide;
  logic signed [31:0] sat;
  logic signed [31:0] sum_r;

  always_comb begin
    wide = {a[31], a} + {b[31], b};
    if (wide[32] != wide[31]) begin
      sat = wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat = wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sat;
    end
  end

  assign sum    = sum_r;
  assign better = !cur_valid || (cur > sum_r);

endmodule

// ----- design/all_pairs_shortest_path.sv -----
// All-pairs shortest path engine (Floyd-Warshall with first/last hop tracking).
// Issue a transaction by raising start while busy is low; busy stays high until
// the transaction is done. Results appear on out_item for exactly one cycle
// with out_strobe high; the receiver cannot stall, so it must take every
// strobe. After reset the whole power-of-two-sized matrix memory is swept to
// all-unreachable with busy high; a clear op runs the same sweep but makes the
// diagonal reachable at distance 0. An edge write completes in idle, a read
// emits from the registered fetch, and a path walk fetches (u,col), then emits,
// for each vertex. One saturating adder/comparator does every relaxation, one
// at a time through the add and compare/write states, paced by the registered
// read of the matrix memory. The vertex_count register is sampled when a run
// starts; write it only when idle.
module all_pairs_shortest_path import apsp_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  apsp_in_t  in_item,
  output logic      out_strobe,
  output apsp_out_t out_item,
  input  logic      cfg_we,
  input  logic [4:0] cfg_wdata
);

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int AW     = 2 * VW;
  localparam int DW     = 33 + 2 * VW;
  localparam int CW     = (VW + 1 > 5) ? VW + 1 : 5;
  localparam int WB_EFF = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int CAP    = (MAX_VERTICES < MAX_RESULTS) ? MAX_VERTICES : MAX_RESULTS;

  // Sequencer states
  localparam logic [3:0] S_INIT = 4'd0;   // post-reset sweep
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;   // clear sweep
  localparam logic [3:0] S_RIK  = 4'd3;   // fetch (i,k)
  localparam logic [3:0] S_RIKD = 4'd4;   // (i,k) data back
  localparam logic [3:0] S_RSUM = 4'd5;   // add d(i,k)+d(k,j)
  localparam logic [3:0] S_RUPD = 4'd6;   // compare, write (i,j)
  localparam logic [3:0] S_NRD  = 4'd7;   // fetch diagonal
  localparam logic [3:0] S_NCHK = 4'd8;   // test diagonal sign
  localparam logic [3:0] S_ROUT = 4'd9;   // run result
  localparam logic [3:0] S_RDD  = 4'd10;  // read result
  localparam logic [3:0] S_PRD  = 4'd11;  // fetch (u,col)
  localparam logic [3:0] S_PEM  = 4'd12;  // emit path vertex

  logic [3:0]         state_r, state_nxt;
  logic [AW-1:0]      sw_r, sw_nxt;
  logic [VW-1:0]      k_r, k_nxt, i_r, i_nxt, j_r, j_nxt, nl_r, nl_nxt;
  logic signed [31:0] ik_dist_r, ik_dist_nxt;
  logic [VW-1:0]      ik_first_r, ik_first_nxt;
  logic               neg_r, neg_nxt;
  logic [4:0]         vc_r;
  logic [VW-1:0]      u_r, u_nxt, c_r, c_nxt;
  logic [3:0]         row4_r, row4_nxt;
  logic               first_r, first_nxt;
  logic [4:0]         count_r, count_nxt;
  logic               oor_r, oor_nxt;
  logic signed [31:0] ent_dist_r, ent_dist_nxt;
  logic [3:0]         ent_next_r, ent_next_nxt, ent_prev_r, ent_prev_nxt;
  logic               out_strobe_r;
  apsp_out_t          out_item_r;

  // Memory ports
  logic          rd_a_en, rd_b_en, wr_en;
  logic [AW-1:0] rd_a_addr, rd_b_addr, wr_addr;
  logic [DW-1:0] rd_a_data, rd_b_data, wr_data;

  logic               rda_reach, rdb_reach;
  logic signed [31:0] rda_dist, rdb_dist;
  logic [VW-1:0]      rda_first, rda_last;

  // Shared relax unit
  logic               alu_en, alu_better;
  logic signed [31:0] alu_sum;

  logic               accept, in_rng, row_end, emit, cont, reach_ok;
  logic signed [31:0] wdist;
  logic [VW-1:0]      in_row, in_col;
  logic [CW-1:0]      vc_ext, n_act;
  apsp_out_t          emit_item;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign in_rng = ({28'd0, in_item.row} < 32'(MAX_VERTICES)) &&
                  ({28'd0, in_item.col} < 32'(MAX_VERTICES));
  assign in_row = VW'(in_item.row);
  assign in_col = VW'(in_item.col);
  assign wdist  = 32'($signed(in_item.weight[WB_EFF-1:0]));

  // Active vertex count: 0 acts as 1, clamp to the matrix size
  assign vc_ext = CW'(vc_r);
  assign n_act  = (vc_r == 5'd0) ? CW'(1) :
                  (vc_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_ext;

  // Entry layout: {reach, dist, first hop, last hop}
  assign rda_reach = rd_a_data[DW-1];
  assign rda_dist  = rd_a_data[DW-2 -: 32];
  assign rda_first = rd_a_data[2*VW-1 -: VW];
  assign rda_last  = rd_a_data[VW-1:0];
  assign rdb_reach = rd_b_data[DW-1];
  assign rdb_dist  = rd_b_data[DW-2 -: 32];

  assign alu_en = (state_r == S_RSUM);

  apsp_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk       (clk),
    .rd_a_en   (rd_a_en),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_en   (rd_b_en),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  apsp_alu u_alu (
    .clk       (clk),
    .en        (alu_en),
    .a         (ik_dist_r),
    .b         (rda_dist),
    .cur       (rdb_dist),
    .cur_valid (rdb_reach),
    .sum       (alu_sum),
    .better    (alu_better)
  );

  always_comb begin
    state_nxt    = state_r;
    sw_nxt       = sw_r;
    k_nxt        = k_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    nl_nxt       = nl_r;
    ik_dist_nxt  = ik_dist_r;
    ik_first_nxt = ik_first_r;
    neg_nxt      = neg_r;
    u_nxt        = u_r;
    c_nxt        = c_r;
    row4_nxt     = row4_r;
    first_nxt    = first_r;
    count_nxt    = count_r;
    oor_nxt      = oor_r;
    ent_dist_nxt = ent_dist_r;
    ent_next_nxt = ent_next_r;
    ent_prev_nxt = ent_prev_r;
    rd_a_en      = 1'b0;
    rd_a_addr    = '0;
    rd_b_en      = 1'b0;
    rd_b_addr    = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    row_end      = 1'b0;
    emit         = 1'b0;
    emit_item    = '0;
    cont         = 1'b0;
    reach_ok     = rda_reach && !oor_r;

    case (state_r)
      S_INIT, S_CLR: begin
        // Diagonal becomes reachable only on a clear, never on reset
        wr_en   = 1'b1;
        wr_addr = sw_r;
        wr_data = {(state_r == S_CLR) && (sw_r[AW-1:VW] == sw_r[VW-1:0]),
                   32'sd0, sw_r[VW-1:0], sw_r[VW-1:0]};
        if (&sw_r) begin
          state_nxt = S_IDLE;
        end else begin
          sw_nxt = sw_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (in_item.op)
            OP_CLEAR: begin
              sw_nxt    = '0;
              neg_nxt   = 1'b0;
              state_nxt = S_CLR;
            end
            OP_WRITE: begin
              if (in_rng) begin
                wr_en   = 1'b1;
                wr_addr = {in_row, in_col};
                wr_data = {1'b1, wdist, in_col, in_row};
              end
            end
            OP_RUN: begin
              k_nxt     = '0;
              i_nxt     = '0;
              nl_nxt    = VW'(n_act - CW'(1));
              state_nxt = S_RIK;
            end
            OP_READ: begin
              rd_a_en   = 1'b1;
              rd_a_addr = {in_row, in_col};
              oor_nxt   = !in_rng;
              state_nxt = S_RDD;
            end
            OP_PATH: begin
              rd_a_en   = 1'b1;
              rd_a_addr = {in_row, in_col};
              oor_nxt   = !in_rng;
              u_nxt     = in_row;
              c_nxt     = in_col;
              row4_nxt  = in_item.row;
              first_nxt = 1'b1;
              count_nxt = '0;
              state_nxt = S_PEM;
            end
            default: ;
          endcase
        end
      end

      S_RIK: begin
        rd_a_en   = 1'b1;
        rd_a_addr = {i_r, k_r};
        state_nxt = S_RIKD;
      end

      S_RIKD: begin
        if (!rda_reach) begin
          row_end = 1'b1;
        end else begin
          ik_dist_nxt  = rda_dist;
          ik_first_nxt = rda_first;
          j_nxt        = '0;
          rd_a_en      = 1'b1;
          rd_a_addr    = {k_r, VW'(0)};
          rd_b_en      = 1'b1;
          rd_b_addr    = {i_r, VW'(0)};
          state_nxt    = S_RSUM;
        end
      end

      S_RSUM: begin
        state_nxt = S_RUPD;
      end

      S_RUPD: begin
        if (rda_reach && alu_better) begin
          wr_en   = 1'b1;
          wr_addr = {i_r, j_r};
          wr_data = {1'b1, alu_sum, ik_first_r, rda_last};
          // (i,k) itself was improved: later sums in this row use it
          if (j_r == k_r) begin
            ik_dist_nxt = alu_sum;
          end
        end
        if (j_r == nl_r) begin
          row_end = 1'b1;
        end else begin
          j_nxt     = j_r + VW'(1);
          rd_a_en   = 1'b1;
          rd_a_addr = {k_r, j_r + VW'(1)};
          rd_b_en   = 1'b1;
          rd_b_addr = {i_r, j_r + VW'(1)};
          state_nxt = S_RSUM;
        end
      end

      S_NRD: begin
        rd_a_en   = 1'b1;
        rd_a_addr = {i_r, i_r};
        state_nxt = S_NCHK;
      end

      S_NCHK: begin
        if (rda_reach && rda_dist[31]) begin
          neg_nxt = 1'b1;
        end
        if (i_r == nl_r) begin
          state_nxt = S_ROUT;
        end else begin
          i_nxt     = i_r + VW'(1);
          state_nxt = S_NRD;
        end
      end

      S_ROUT: begin
        emit                = 1'b1;
        emit_item.neg_cycle = neg_r;
        emit_item.last      = 1'b1;
        state_nxt           = S_IDLE;
      end

      S_RDD: begin
        emit = 1'b1;
        if (reach_ok) begin
          emit_item.distance  = rda_dist;
          emit_item.reachable = 1'b1;
          emit_item.next_hop  = 4'(rda_first);
          emit_item.prev_hop  = 4'(rda_last);
        end
        emit_item.neg_cycle = neg_r;
        emit_item.last      = 1'b1;
        state_nxt           = S_IDLE;
      end

      S_PRD: begin
        rd_a_en   = 1'b1;
        rd_a_addr = {u_r, c_r};
        state_nxt = S_PEM;
      end

      S_PEM: begin
        emit                = 1'b1;
        emit_item.neg_cycle = neg_r;
        if (first_r && !reach_ok) begin
          emit_item.path_vertex = row4_r;
          emit_item.last        = 1'b1;
          state_nxt             = S_IDLE;
        end else begin
          if (first_r) begin
            ent_dist_nxt = rda_dist;
            ent_next_nxt = 4'(rda_first);
            ent_prev_nxt = 4'(rda_last);
          end
          emit_item.distance    = first_r ? rda_dist : ent_dist_r;
          emit_item.reachable   = 1'b1;
          emit_item.next_hop    = first_r ? 4'(rda_first) : ent_next_r;
          emit_item.prev_hop    = first_r ? 4'(rda_last) : ent_prev_r;
          emit_item.path_vertex = first_r ? row4_r : 4'(u_r);
          // Step on while short of col, under the cap, and (u,col) reachable
          cont = (u_r != c_r) && ((count_r + 5'd1) < 5'(CAP)) && rda_reach;
          emit_item.last = !cont;
          if (cont) begin
            u_nxt     = rda_first;
            count_nxt = count_r + 5'd1;
            first_nxt = 1'b0;
            state_nxt = S_PRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Row i done for this k: next i, next k, or on to the diagonal check
    if (row_end) begin
      if (i_r == nl_r) begin
        i_nxt = '0;
        if (k_r == nl_r) begin
          neg_nxt   = 1'b0;
          state_nxt = S_NRD;
        end else begin
          k_nxt     = k_r + VW'(1);
          state_nxt = S_RIK;
        end
      end else begin
        i_nxt     = i_r + VW'(1);
        state_nxt = S_RIK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      sw_r         <= '0;
      neg_r        <= 1'b0;
      vc_r         <= VCOUNT_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sw_r         <= sw_nxt;
      neg_r        <= neg_nxt;
      out_strobe_r <= emit;
      if (cfg_we) begin
        vc_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    nl_r       <= nl_nxt;
    ik_dist_r  <= ik_dist_nxt;
    ik_first_r <= ik_first_nxt;
    u_r        <= u_nxt;
    c_r        <= c_nxt;
    row4_r     <= row4_nxt;
    first_r    <= first_nxt;
    count_r    <= count_nxt;
    oor_r      <= oor_nxt;
    ent_dist_r <= ent_dist_nxt;
    ent_next_r <= ent_next_nxt;
    ent_prev_r <= ent_prev_nxt;
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
